@@ rtl/core/hks_pkg.sv @@
// shared constants, codes and control types for the histogram k-th smallest block
package hks_pkg;

  localparam int NUM_BINS     = 1024;
  localparam int VALUE_OFFSET = 512;
  localparam int COUNT_BITS   = 16;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 10;
  localparam int RANK_W  = 16;
  localparam int STAT_W  = 2;

  localparam int BIN_BITS = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int OFF_BITS = $clog2(VALUE_OFFSET + 1);

  // signed width that holds any value plus offset and the bin count itself
  localparam int BIDX_A = (BIN_BITS + 1 > VALUE_W) ? BIN_BITS + 1 : VALUE_W;
  localparam int BIDX_W = ((BIDX_A > OFF_BITS) ? BIDX_A : OFF_BITS) + 1;

  // compare widths for rank against total and running sum
  localparam int RK_W  = (RANK_W > COUNT_BITS) ? RANK_W : COUNT_BITS;
  localparam int CMP_W = (RANK_W > COUNT_BITS + 1) ? RANK_W : COUNT_BITS + 1;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_VALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_UPDATE,
    S_SCAN,
    S_RESULT
  } hks_state_e;

  typedef struct packed {
    logic              in_ready;
    logic              capture;
    logic              clr_wr;
    logic              rd_bin;
    logic              upd_bin;
    logic              scan_init;
    logic              scan_run;
    logic              res_set;
    logic [STAT_W-1:0] res_code;
    logic              out_load;
  } hks_ctrl_t;

  typedef struct packed {
    logic             in_valid;
    logic             clr_last;
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             in_range;
    logic             rank_over;
    logic             hit;
    logic             scan_end;
    logic             out_free;
  } hks_stat_t;

endpackage

@@ rtl/core/hks_req_if.sv @@
// request channel: command, value and rank with valid/ready
interface hks_req_if
  import hks_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] value;
  logic [RANK_W-1:0]         rank;

  modport source (output valid, cmd, value, rank, input ready);
  modport sink   (input valid, cmd, value, rank, output ready);
endinterface

@@ rtl/core/hks_rsp_if.sv @@
// response channel: status and answer with valid/ready
interface hks_rsp_if
  import hks_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic signed [VALUE_W-1:0] answer;

  modport source (output valid, status, answer, input ready);
  modport sink   (input valid, status, answer, output ready);
endinterface

@@ rtl/core/hks_ctrl.sv @@
// controller state machine: clearing pass, command dispatch, bin update, bin scan, result handoff
module hks_ctrl
  import hks_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hks_stat_t stat_i,
  output hks_ctrl_t ctrl_o
);

  hks_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (stat_i.in_valid) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.cmd)
          CMD_ADD: begin
            state_d = (!stat_i.full && stat_i.in_range) ? S_UPDATE : S_RESULT;
          end
          CMD_DEL: begin
            state_d = stat_i.in_range ? S_UPDATE : S_RESULT;
          end
          CMD_QUERY: begin
            state_d = stat_i.rank_over ? S_RESULT : S_SCAN;
          end
          default: begin
            state_d = S_RESULT;
          end
        endcase
      end
      S_UPDATE: begin
        state_d = S_RESULT;
      end
      S_SCAN: begin
        if (stat_i.hit || stat_i.scan_end) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.res_code = ST_DONE;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.clr_wr = 1'b1;
      end
      S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.capture  = stat_i.in_valid;
      end
      S_DISPATCH: begin
        unique case (stat_i.cmd)
          CMD_ADD: begin
            if (stat_i.full) begin
              ctrl_o.res_set  = 1'b1;
              ctrl_o.res_code = ST_FULL;
            end else if (stat_i.in_range) begin
              ctrl_o.rd_bin = 1'b1;
            end else begin
              ctrl_o.res_set = 1'b1;
            end
          end
          CMD_DEL: begin
            if (stat_i.in_range) begin
              ctrl_o.rd_bin = 1'b1;
            end else begin
              ctrl_o.res_set = 1'b1;
            end
          end
          CMD_QUERY: begin
            if (stat_i.rank_over) begin
              ctrl_o.res_set  = 1'b1;
              ctrl_o.res_code = ST_SHORT;
            end else begin
              ctrl_o.scan_init = 1'b1;
            end
          end
          default: begin
            ctrl_o.res_set = 1'b1;
          end
        endcase
      end
      S_UPDATE: begin
        ctrl_o.upd_bin = 1'b1;
        ctrl_o.res_set = 1'b1;
      end
      S_SCAN: begin
        ctrl_o.scan_run = 1'b1;
        if (stat_i.hit) begin
          ctrl_o.res_set  = 1'b1;
          ctrl_o.res_code = ST_VALID;
        end else if (stat_i.scan_end) begin
          ctrl_o.res_set  = 1'b1;
          ctrl_o.res_code = ST_SHORT;
        end
      end
      S_RESULT: begin
        ctrl_o.out_load = stat_i.out_free;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/hks_dpath.sv @@
// datapath: bin memory, total, scan address and running sum, result and output registers
module hks_dpath
  import hks_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hks_ctrl_t ctrl_i,
  output hks_stat_t stat_o,
  hks_req_if.sink   req_i,
  hks_rsp_if.source rsp_o
);

  logic [COUNT_BITS-1:0] bins_mem [NUM_BINS];
  logic [COUNT_BITS-1:0] rdata_q;

  logic [BIN_BITS-1:0]   clr_idx_q;
  logic [COUNT_BITS-1:0] total_q, total_d;

  logic [CMD_W-1:0]          cmd_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [RANK_W-1:0]         rank_q;

  logic [BIN_BITS-1:0]   scan_addr_q;
  logic                  scan_more_q;
  logic [BIN_BITS-1:0]   rd_idx_q;
  logic                  rd_valid_q;
  logic [COUNT_BITS-1:0] sum_q;

  logic [STAT_W-1:0]  res_status_q;
  logic [VALUE_W-1:0] res_answer_q;
  logic               out_valid_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [VALUE_W-1:0] out_answer_q;

  logic [BIDX_W-1:0]     bin_s;
  logic [BIN_BITS-1:0]   bin_idx;
  logic                  in_range;
  logic                  is_add;
  logic [CMP_W-1:0]      sum_next;
  logic                  hit;
  logic [BIDX_W-1:0]     hit_diff;
  logic                  wr_en;
  logic [BIN_BITS-1:0]   wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [BIN_BITS-1:0]   rd_addr;
  logic                  out_free;

  // value to bin index, with range check in a signed width that cannot wrap
  assign bin_s    = {{(BIDX_W-VALUE_W){value_q[VALUE_W-1]}}, value_q} + BIDX_W'(VALUE_OFFSET);
  assign in_range = !bin_s[BIDX_W-1] && (bin_s < BIDX_W'(NUM_BINS));
  assign bin_idx  = bin_s[BIN_BITS-1:0];
  assign is_add   = (cmd_q == CMD_ADD);

  assign sum_next = CMP_W'(sum_q) + CMP_W'(rdata_q);
  assign hit      = rd_valid_q && (sum_next >= CMP_W'(rank_q));
  assign hit_diff = BIDX_W'(rd_idx_q) - BIDX_W'(VALUE_OFFSET);

  assign out_free = !out_valid_q || rsp_o.ready;

  // single write port and single read port
  assign wr_en   = ctrl_i.clr_wr || ctrl_i.upd_bin;
  assign wr_addr = ctrl_i.clr_wr ? clr_idx_q : bin_idx;
  assign wr_data = (ctrl_i.upd_bin && is_add) ? rdata_q + COUNT_BITS'(1) : '0;
  assign rd_en   = ctrl_i.rd_bin || (ctrl_i.scan_run && scan_more_q);
  assign rd_addr = ctrl_i.rd_bin ? bin_idx : scan_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bins_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= bins_mem[rd_addr];
    end
  end

  always_comb begin
    total_d = total_q;
    if (ctrl_i.upd_bin) begin
      total_d = is_add ? total_q + COUNT_BITS'(1) : total_q - rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q   <= '0;
      total_q     <= '0;
      scan_more_q <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      if (ctrl_i.clr_wr) begin
        clr_idx_q <= clr_idx_q + BIN_BITS'(1);
      end
      if (ctrl_i.scan_init) begin
        scan_more_q <= 1'b1;
        rd_valid_q  <= 1'b0;
      end else if (ctrl_i.scan_run) begin
        rd_valid_q <= scan_more_q;
        if (scan_more_q && (scan_addr_q == BIN_BITS'(NUM_BINS - 1))) begin
          scan_more_q <= 1'b0;
        end
      end else begin
        rd_valid_q <= 1'b0;
      end
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= req_i.cmd;
      value_q <= req_i.value;
      rank_q  <= req_i.rank;
    end
    if (ctrl_i.scan_init) begin
      scan_addr_q <= '0;
      sum_q       <= '0;
    end else if (ctrl_i.scan_run) begin
      if (scan_more_q) begin
        rd_idx_q    <= scan_addr_q;
        scan_addr_q <= scan_addr_q + BIN_BITS'(1);
      end
      if (rd_valid_q) begin
        sum_q <= sum_next[COUNT_BITS-1:0];
      end
    end
    if (ctrl_i.res_set) begin
      res_status_q <= ctrl_i.res_code;
      res_answer_q <= (ctrl_i.res_code == ST_VALID) ? hit_diff[VALUE_W-1:0] : '0;
    end
    if (ctrl_i.out_load) begin
      out_status_q <= res_status_q;
      out_answer_q <= res_answer_q;
    end
  end

  assign req_i.ready  = ctrl_i.in_ready;
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.answer = out_answer_q;

  assign stat_o.in_valid  = req_i.valid;
  assign stat_o.clr_last  = (clr_idx_q == BIN_BITS'(NUM_BINS - 1));
  assign stat_o.cmd       = cmd_q;
  assign stat_o.full      = (total_q == '1);
  assign stat_o.in_range  = in_range;
  assign stat_o.rank_over = RK_W'(rank_q) > RK_W'(total_q);
  assign stat_o.hit       = hit;
  assign stat_o.scan_end  = rd_valid_q && !hit && (rd_idx_q == BIN_BITS'(NUM_BINS - 1));
  assign stat_o.out_free  = out_free;

  // running sum only covers bins below the current one, so it stays within the total
  a_sum_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (sum_q <= total_q))
    else $error("scan running sum exceeds total");

  // result is only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> out_free)
    else $error("output register overwritten");

  // an accepted add raises the total by exactly one
  a_add_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.upd_bin && is_add) |=> (total_q == $past(total_q) + COUNT_BITS'(1)))
    else $error("total not incremented on add");

endmodule

@@ rtl/core/histogram_kth_smallest.sv @@
// Histogram k-th smallest: an accepted add or in-range delete goes from dispatch through
// the bin update to result, a refused query or other request straight to result. A query
// scans one bin per cycle through the single read port; one item in flight, the next
// request taken once the response is loaded, even while it still waits for a transfer.
// After reset a clearing pass writes zero to all NUM_BINS (1024) bins, one per cycle;
// no request is accepted until it ends. Reset is asynchronous, active low.
module histogram_kth_smallest
  import hks_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  hks_req_if.sink   req_i,
  hks_rsp_if.source rsp_o
);

  hks_ctrl_t ctrl;
  hks_stat_t stat;

  hks_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  hks_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

@@ tb/tb_histogram_kth_smallest.sv @@
// self-checking testbench for the histogram k-th smallest block
module tb_histogram_kth_smallest;
  import hks_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int               WATCHDOG_LIMIT = 6000;
  localparam int               RANDOM_ITEMS = 540;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] answer;
  } hks_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  hks_req_if req ();
  hks_rsp_if rsp ();

  histogram_kth_smallest dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow histogram, updated at each request transfer
  logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
  logic [COUNT_BITS-1:0] hist_total;
  hks_rsp_t              due_responses [$];
  int                    err_cnt = 0;

  // sender and receiver idling controls
  bit tx_bursty = 1'b1;
  int burst_left = 0;
  bit rx_free = 1'b0;
  int rx_hold_left = 0;

  function automatic hks_rsp_t histogram_apply(input logic [CMD_W-1:0] c,
                                               input logic signed [VALUE_W-1:0] v,
                                               input logic [RANK_W-1:0] k);
    hks_rsp_t    r;
    int          idx;
    int unsigned run;
    bit          found;
    r.status = ST_DONE;
    r.answer = '0;
    idx = int'(v) + VALUE_OFFSET;
    case (c)
      CMD_ADD: begin
        if (hist_total == '1) begin
          r.status = ST_FULL;
        end else if (idx >= 0 && idx < NUM_BINS) begin
          hist_bins[idx]++;
          hist_total++;
        end
      end
      CMD_DEL: begin
        if (idx >= 0 && idx < NUM_BINS) begin
          hist_total -= hist_bins[idx];
          hist_bins[idx] = '0;
        end
      end
      CMD_QUERY: begin
        r.status = ST_SHORT;
        if (k <= hist_total) begin
          run = 0;
          found = 1'b0;
          for (int i = 0; i < NUM_BINS; i++) begin
            if (!found) begin
              run += hist_bins[i];
              if (run >= k) begin
                found = 1'b1;
                r.status = ST_VALID;
                r.answer = VALUE_W'(i - VALUE_OFFSET);
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_req(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v,
                          input logic [RANK_W-1:0] k);
    int gap;
    if (tx_bursty && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    req.valid <= 1'b1;
    req.cmd   <= c;
    req.value <= v;
    req.rank  <= k;
    do @(posedge clk); while (!req.ready);
    due_responses.push_back(histogram_apply(c, v, k));
    if (burst_left > 0) burst_left--;
  endtask

  // sender goes quiet until every outstanding response has come back
  task automatic wait_drained();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_responses.size() > 0);
  endtask

  task automatic test_directed();
    send_req(CMD_NONE, -10'sd1, 16'hFFFF);
    send_req(CMD_QUERY, 10'sd0, 16'd0);
    send_req(CMD_QUERY, 10'sd0, 16'd1);
    send_req(CMD_ADD, -10'sd512, 16'hFFFF);
    send_req(CMD_ADD, 10'sd511, 16'd0);
    send_req(CMD_ADD, 10'sd0, 16'd0);
    send_req(CMD_ADD, 10'sd0, 16'd0);
    for (int k = 0; k <= 5; k++) send_req(CMD_QUERY, 10'sd0, RANK_W'(k));
    send_req(CMD_QUERY, -10'sd1, 16'hFFFF);
    send_req(CMD_DEL, 10'sd0, 16'd0);
    send_req(CMD_QUERY, 10'sd0, 16'd2);
    send_req(CMD_DEL, 10'sd5, 16'd0);
    send_req(CMD_NONE, 10'sd0, 16'd0);
    send_req(CMD_DEL, -10'sd512, 16'd0);
    send_req(CMD_DEL, 10'sd511, 16'd0);
    send_req(CMD_QUERY, 10'sd0, 16'd0);
    send_req(CMD_QUERY, 10'sd0, 16'd1);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    tx_bursty = 1'b0;
    rx_hold_left = 300;
    for (int n = 0; n < 12; n++)
      send_req((n % 3 == 2) ? CMD_QUERY : CMD_ADD, VALUE_W'($urandom_range(0, 1023)),
               RANK_W'($urandom_range(0, n)));
    wait_drained();
    tx_bursty = 1'b1;
  endtask

  task automatic test_random();
    logic signed [VALUE_W-1:0] pool [16];
    logic signed [VALUE_W-1:0] v;
    logic [CMD_W-1:0]          c;
    logic [RANK_W-1:0]         k;
    int                        pick;
    int                        top;
    pool[0] = -10'sd512;
    pool[1] = 10'sd511;
    pool[2] = 10'sd0;
    for (int i = 3; i < 16; i++) pool[i] = VALUE_W'($urandom_range(0, 1023));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 90 == 89) begin
        tx_bursty = 1'($urandom_range(0, 1));
        rx_free = $urandom_range(0, 2) == 0;
      end
      if (n % 150 == 75) rx_hold_left = $urandom_range(50, 200);
      if (n % 200 == 199) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 45) c = CMD_ADD;
      else if (pick < 60) c = CMD_DEL;
      else if (pick < 95) c = CMD_QUERY;
      else c = CMD_NONE;
      v = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom_range(0, 1023))
                                      : pool[$urandom_range(0, 15)];
      top = int'(hist_total) + 1;
      if (top > 65535) top = 65535;
      k = ($urandom_range(0, 3) == 0) ? RANK_W'($urandom_range(0, 65535))
                                      : RANK_W'($urandom_range(0, top));
      send_req(c, v, k);
    end
    wait_drained();
  endtask

  // response side: check each transfer, then pick next ready
  initial begin : rsp_side
    logic [15:0] rx_pat;
    int          rx_pos;
    hks_rsp_t    want;
    rx_pat = 16'hB5E3;
    rx_pos = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (due_responses.size() == 0) begin
          $error("response with nothing outstanding: status %0d answer %0d",
                 rsp.status, $signed(rsp.answer));
          err_cnt++;
        end else begin
          want = due_responses.pop_front();
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
            err_cnt++;
          end
          if (rsp.answer !== want.answer) begin
            $error("answer mismatch: expected %0d, got %0d",
                   $signed(want.answer), $signed(rsp.answer));
            err_cnt++;
          end
        end
      end
      if (rx_hold_left > 0) begin
        rsp.ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_free) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= rx_pat[rx_pos];
        rx_pos++;
        if (rx_pos == 16) begin
          rx_pos = 0;
          rx_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
      end
    end
  end

  // watchdog on cycles without any transfer; covers the clearing pass too
  initial begin : watchdog
    int idle_cyc;
    idle_cyc = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    foreach (hist_bins[i]) hist_bins[i] = '0;
    hist_total = '0;
    rst_n     <= 1'b0;
    req.valid <= 1'b0;
    req.cmd   <= CMD_NONE;
    req.value <= '0;
    req.rank  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk);
    if (err_cnt == 0 && due_responses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/hks_pkg.sv
rtl/core/hks_req_if.sv
rtl/core/hks_rsp_if.sv
rtl/core/hks_ctrl.sv
rtl/core/hks_dpath.sv
rtl/core/histogram_kth_smallest.sv
tb/tb_histogram_kth_smallest.sv
